// ----- hw/rtl/tcc_pkg.sv -----
// shared types and constants for the triggered four channel capture block
// no dependencies; used by tcc_ctrl, tcc_store and the top level
`default_nettype none

package tcc_pkg;

    // store geometry and field widths
    localparam int unsigned DEPTH   = 256;
    localparam int unsigned ADDR_W  = 8;
    localparam int unsigned FILL_W  = 9;
    localparam int unsigned SMP_W   = 16;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned ENTRY_W = 4 * SMP_W;

    // stream payload widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 80;

    // apb
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TRIG_MODE    = 3'd0;
    localparam logic [2:0] REG_TRIG_CHANNEL = 3'd1;
    localparam logic [2:0] REG_TRIG_LEVEL   = 3'd2;
    localparam logic [2:0] REG_TRIG_RISING  = 3'd3;
    localparam logic [2:0] REG_HOLDOFF      = 3'd4;

    // trigger modes
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    // trigger channel codes
    localparam logic [2:0] CHAN_B = 3'd2;
    localparam logic [2:0] CHAN_C = 3'd3;
    localparam logic [2:0] CHAN_D = 3'd4;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_ARM  = 2'd1,
        PH_RUN  = 2'd2,
        PH_HOLD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // one input item
    typedef struct packed {
        logic [ADDR_W-1:0]       read_address;
        logic signed [SMP_W-1:0] sample_d;
        logic signed [SMP_W-1:0] sample_c;
        logic signed [SMP_W-1:0] sample_b;
        logic signed [SMP_W-1:0] sample_a;
        t_cmd                    command;
    } t_item;

    // configuration registers
    typedef struct packed {
        logic [1:0]              trig_mode;
        logic [2:0]              trig_channel;
        logic signed [SMP_W-1:0] trig_level;
        logic                    trig_rising;
        logic [HOLD_W-1:0]       holdoff_samples;
    } t_cfg;

    // store control from the capture controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              clear;
    } t_store_ctl;

    // status of one processed item
    typedef struct packed {
        t_phase            phase;
        logic [FILL_W-1:0] fill_count;
        logic              capture_done;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/tcc_ctrl.sv -----
// capture controller: phase machine, edge trigger, fill index and holdoff counter
// depends on tcc_pkg
`default_nettype none

module tcc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire tcc_pkg::t_item     i_item,
    input  wire tcc_pkg::t_cfg      i_cfg,
    output tcc_pkg::t_status        o_status,
    output tcc_pkg::t_store_ctl     o_store_ctl
);

    localparam logic [tcc_pkg::FILL_W-1:0] FILL_FULL = tcc_pkg::FILL_W'(tcc_pkg::DEPTH);

    tcc_pkg::t_phase                    r_phase, n_phase;
    logic [tcc_pkg::FILL_W-1:0]         r_fill, n_fill;
    logic [tcc_pkg::HOLD_W-1:0]         r_hold, n_hold;
    logic signed [tcc_pkg::SMP_W-1:0]   r_prev, n_prev;
    logic                               r_prev_valid, n_prev_valid;

    logic signed [tcc_pkg::SMP_W-1:0]   cur;
    logic                               edge_mode;
    logic                               trig_hit;
    logic                               start;
    logic                               running;
    logic [tcc_pkg::FILL_W-1:0]         fill_inc;
    logic                               full;
    logic                               in_hold;
    logic [tcc_pkg::HOLD_W-1:0]         hold_val;
    logic                               hold_end;
    logic                               is_sample;

    // trigger channel select
    always_comb begin
        unique case (i_cfg.trig_channel)
            tcc_pkg::CHAN_B: cur = i_item.sample_b;
            tcc_pkg::CHAN_C: cur = i_item.sample_c;
            tcc_pkg::CHAN_D: cur = i_item.sample_d;
            default:         cur = i_item.sample_a;
        endcase
    end

    // strict level crossing against the previous compared value
    assign edge_mode = (i_cfg.trig_mode == tcc_pkg::MODE_NORMAL) ||
                       (i_cfg.trig_mode == tcc_pkg::MODE_SINGLE);
    assign trig_hit  = r_prev_valid &&
                       (i_cfg.trig_rising ? (r_prev < i_cfg.trig_level && cur > i_cfg.trig_level)
                                          : (r_prev > i_cfg.trig_level && cur < i_cfg.trig_level));

    // shared step flags
    assign is_sample = (i_item.command == tcc_pkg::CMD_SAMPLE);
    assign start     = (r_phase == tcc_pkg::PH_ARM) &&
                       ((i_cfg.trig_mode == tcc_pkg::MODE_AUTO) || (edge_mode && trig_hit));
    assign running   = (r_phase == tcc_pkg::PH_RUN) || start;
    assign fill_inc  = r_fill + tcc_pkg::FILL_W'(1);
    assign full      = running && (fill_inc >= FILL_FULL);
    assign in_hold   = full || (r_phase == tcc_pkg::PH_HOLD);
    assign hold_val  = full ? i_cfg.holdoff_samples : r_hold;
    assign hold_end  = in_hold && (hold_val == '0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (i_item.command)
            tcc_pkg::CMD_ARM:  n_phase = tcc_pkg::PH_ARM;
            tcc_pkg::CMD_STOP: n_phase = tcc_pkg::PH_STOP;
            tcc_pkg::CMD_READ: n_phase = r_phase;
            default: begin
                priority if (hold_end) begin
                    n_phase = (i_cfg.trig_mode == tcc_pkg::MODE_SINGLE) ? tcc_pkg::PH_STOP
                                                                        : tcc_pkg::PH_ARM;
                end else if (in_hold) begin
                    n_phase = tcc_pkg::PH_HOLD;
                end else if (running) begin
                    n_phase = tcc_pkg::PH_RUN;
                end else begin
                    n_phase = r_phase;
                end
            end
        endcase
    end

    // fill index, holdoff counter and trigger history
    always_comb begin
        n_fill       = r_fill;
        n_hold       = r_hold;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        unique case (i_item.command)
            tcc_pkg::CMD_ARM: begin
                n_fill       = '0;
                n_prev_valid = 1'b0;
            end
            tcc_pkg::CMD_STOP: begin
                n_fill       = '0;
                n_hold       = '0;
                n_prev_valid = 1'b0;
            end
            tcc_pkg::CMD_READ: begin
                n_fill = r_fill;
            end
            default: begin
                if (r_phase == tcc_pkg::PH_ARM && edge_mode) begin
                    n_prev       = cur;
                    n_prev_valid = 1'b1;
                end
                if (hold_end) begin
                    n_fill = '0;
                end else if (running) begin
                    n_fill = fill_inc;
                end
                if (in_hold) begin
                    n_hold = hold_end ? '0 : hold_val - tcc_pkg::HOLD_W'(1);
                end
            end
        endcase
    end

    // status and store control for this item
    always_comb begin
        o_status.phase        = n_phase;
        o_status.fill_count   = n_fill;
        o_status.capture_done = is_sample && full;
        o_store_ctl.we        = i_step && is_sample && running && !r_fill[tcc_pkg::FILL_W-1];
        o_store_ctl.waddr     = r_fill[tcc_pkg::ADDR_W-1:0];
        o_store_ctl.clear     = i_step && ((i_item.command == tcc_pkg::CMD_ARM) ||
                                           (i_item.command == tcc_pkg::CMD_STOP));
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tcc_pkg::PH_STOP;
            r_fill       <= '0;
            r_hold       <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_fill       <= n_fill;
            r_hold       <= n_hold;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tcc_store.sv -----
// capture store: four-channel sample memory with per-entry written marks
// depends on tcc_pkg; read data is registered, unwritten entries read zero
`default_nettype none

module tcc_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire tcc_pkg::t_store_ctl           i_ctl,
    input  wire logic [tcc_pkg::ENTRY_W-1:0]   i_wdata,
    input  wire logic                          i_rd,
    input  wire logic [tcc_pkg::ADDR_W-1:0]    i_raddr,
    output logic [tcc_pkg::ENTRY_W-1:0]        o_rdata
);

    logic [tcc_pkg::ENTRY_W-1:0] r_mem [tcc_pkg::DEPTH];
    logic [tcc_pkg::DEPTH-1:0]   r_written;
    logic [tcc_pkg::ENTRY_W-1:0] r_rd_q;
    logic                        r_hit;

    // sample memory write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
    end

    // sample memory read port, held while the result stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_q <= r_mem[i_raddr];
        end
    end

    // written marks, cleared together on arm or stop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_hit     <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_written <= '0;
            end else if (i_ctl.we) begin
                r_written[i_ctl.waddr] <= 1'b1;
            end
            if (i_en) begin
                r_hit <= i_rd && r_written[i_raddr];
            end
        end
    end

    assign o_rdata = r_hit ? r_rd_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/triggered_four_channel_capture.sv -----
// path: each item is registered in the input register and then in the result register
// throughput: one item per cycle unless the output is held; one store write and read per cycle
// only a held output stalls the result register, and the input register too unless it is empty
// reset: synchronous active low; state registers to defaults, phase stopped, written marks clear
// no clearing pass over the store: unwritten entries are masked by their written marks
// depends on tcc_pkg, tcc_ctrl and tcc_store
`default_nettype none

module triggered_four_channel_capture (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // command[1:0], sample_a[17:2], sample_b[33:18], sample_c[49:34],
    // sample_d[65:50], read_address[73:66], zero[79:74]
    input  wire logic [tcc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // result stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // phase[1:0], fill_count[10:2], capture_done[11], read_a[27:12],
    // read_b[43:28], read_c[59:44], read_d[75:60], zero[79:76]
    output logic [tcc_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // configuration port
    input  wire logic                               i_psel,
    input  wire logic                               i_penable,
    input  wire logic                               i_pwrite,
    input  wire logic [tcc_pkg::PADDR_W-1:0]        i_paddr,
    input  wire logic [tcc_pkg::PDATA_W-1:0]        i_pwdata,
    output logic [tcc_pkg::PDATA_W-1:0]             o_prdata,
    output logic                                    o_pready
);

    tcc_pkg::t_cfg                r_cfg;
    tcc_pkg::t_item               r_item;
    logic                         r_in_valid;
    tcc_pkg::t_status             r_status;
    logic                         r_out_valid;

    logic                         advance;
    logic                         step;
    logic                         cfg_wr;
    logic [2:0]                   reg_idx;
    tcc_pkg::t_status             status;
    tcc_pkg::t_store_ctl          store_ctl;
    logic [tcc_pkg::ENTRY_W-1:0]  rdata;

    // configuration registers
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign reg_idx  = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_mode       <= tcc_pkg::MODE_AUTO;
            r_cfg.trig_channel    <= 3'd1;
            r_cfg.trig_level      <= '0;
            r_cfg.trig_rising     <= 1'b1;
            r_cfg.holdoff_samples <= tcc_pkg::HOLD_W'(1000);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                tcc_pkg::REG_TRIG_MODE:    r_cfg.trig_mode       <= i_pwdata[1:0];
                tcc_pkg::REG_TRIG_CHANNEL: r_cfg.trig_channel    <= i_pwdata[2:0];
                tcc_pkg::REG_TRIG_LEVEL:   r_cfg.trig_level      <= i_pwdata[15:0];
                tcc_pkg::REG_TRIG_RISING:  r_cfg.trig_rising     <= i_pwdata[0];
                tcc_pkg::REG_HOLDOFF:      r_cfg.holdoff_samples <= i_pwdata[15:0];
                default:                   r_cfg.trig_mode       <= r_cfg.trig_mode;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            tcc_pkg::REG_TRIG_MODE:    o_prdata = {30'd0, r_cfg.trig_mode};
            tcc_pkg::REG_TRIG_CHANNEL: o_prdata = {29'd0, r_cfg.trig_channel};
            tcc_pkg::REG_TRIG_LEVEL:   o_prdata = {16'd0, r_cfg.trig_level};
            tcc_pkg::REG_TRIG_RISING:  o_prdata = {31'd0, r_cfg.trig_rising};
            tcc_pkg::REG_HOLDOFF:      o_prdata = {16'd0, r_cfg.holdoff_samples};
            default:                   o_prdata = '0;
        endcase
    end

    // pipeline advance: both stages move unless a result is held; an empty input stage still fills
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_item.command      <= tcc_pkg::t_cmd'(i_s_axis_tdata[1:0]);
            r_item.sample_a     <= i_s_axis_tdata[17:2];
            r_item.sample_b     <= i_s_axis_tdata[33:18];
            r_item.sample_c     <= i_s_axis_tdata[49:34];
            r_item.sample_d     <= i_s_axis_tdata[65:50];
            r_item.read_address <= i_s_axis_tdata[73:66];
        end
    end

    // capture controller
    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .o_status    (status),
        .o_store_ctl (store_ctl)
    );

    // sample store
    tcc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctl   (store_ctl),
        .i_wdata ({r_item.sample_d, r_item.sample_c, r_item.sample_b, r_item.sample_a}),
        .i_rd    (step && (r_item.command == tcc_pkg::CMD_READ)),
        .i_raddr (r_item.read_address),
        .o_rdata (rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status <= status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, rdata, r_status.capture_done,
                              r_status.fill_count, r_status.phase};

endmodule

`default_nettype wire

// ----- test/tb_triggered_four_channel_capture.sv -----
// self-checking testbench for the triggered four channel capture block
// uses tcc_pkg types and constants; drives the stream and apb ports of the top level
`timescale 1ns / 1ps

module tb_triggered_four_channel_capture;
    import tcc_pkg::*;

    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          RAND_ITEMS  = 900;
    localparam int          PRINT_CAP   = 100;
    // mode code with no package name: never triggers
    localparam logic [1:0]  MODE_NONE   = 2'd3;

    // one expected result
    typedef struct packed {
        logic [1:0]  phase;
        logic [8:0]  fill;
        logic        done;
        logic [63:0] rd;      // {d, c, b, a}
    } t_capture_status;

    // one row of the directed table
    typedef struct {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        t_cmd        cmd;
        logic [15:0] a, b, c, d;
        logic [7:0]  addr;
        int          reps;
        bit          rnd;
        bit          typed;
        t_phase      ph;
        logic [8:0]  fill;
        logic        done;
    } t_dir_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [79:0] in_data = '0;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    wire         s_ready;
    wire         m_valid;
    wire  [79:0] m_data;
    wire  [31:0] prdata;
    wire         pready;

    triggered_four_channel_capture u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (m_data),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    // predicted capture state and register copies
    logic [1:0]         cfg_mode = MODE_AUTO;
    logic [2:0]         cfg_chan = 3'd1;
    logic signed [15:0] cfg_level = '0;
    logic               cfg_rising = 1'b1;
    logic [15:0]        cfg_holdoff = 16'd1000;

    t_phase             cap_phase = PH_STOP;
    int                 fill_idx = 0;
    logic [15:0]        hold_left = '0;
    logic signed [15:0] prev_val = '0;
    bit                 prev_ok = 1'b0;
    logic [63:0]        sample_store [DEPTH];
    bit                 entry_marked [DEPTH];
    int                 ever_top = 0;     // entries 0..ever_top-1 have been written since reset

    t_capture_status    status_q [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    bit                 send_calm = 1'b0;
    bit                 recv_calm = 1'b0;

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic int chan_index(input logic [2:0] sel);
        case (sel)
            CHAN_B:  return 1;
            CHAN_C:  return 2;
            CHAN_D:  return 3;
            default: return 0;
        endcase
    endfunction

    // idle length: mostly short, a few long, with calm stretches of none
    function automatic int idle_len(inout bit calm);
        int r;
        if ($urandom_range(0, 99) == 0) calm = !calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    task automatic clear_capture();
        fill_idx = 0;
        prev_ok  = 1'b0;
        foreach (entry_marked[i]) entry_marked[i] = 1'b0;
    endtask

    // advance the capture state by one accepted item and form its status
    task automatic advance_capture(input t_item it, output t_capture_status st);
        logic signed [15:0] smp [4];
        int                 ch;
        bit                 fire;
        smp[0] = it.sample_a;
        smp[1] = it.sample_b;
        smp[2] = it.sample_c;
        smp[3] = it.sample_d;
        st = '0;
        case (it.command)
            CMD_ARM: begin
                clear_capture();
                cap_phase = PH_ARM;
            end
            CMD_STOP: begin
                clear_capture();
                hold_left = '0;
                cap_phase = PH_STOP;
            end
            CMD_READ: begin
                if (entry_marked[it.read_address]) st.rd = sample_store[it.read_address];
            end
            default: begin
                // trigger search while armed
                if (cap_phase == PH_ARM) begin
                    if (cfg_mode == MODE_AUTO) begin
                        cap_phase = PH_RUN;
                    end else if (cfg_mode == MODE_NORMAL || cfg_mode == MODE_SINGLE) begin
                        ch = chan_index(cfg_chan);
                        if (cfg_rising)
                            fire = (prev_val < cfg_level) && (smp[ch] > cfg_level);
                        else
                            fire = (prev_val > cfg_level) && (smp[ch] < cfg_level);
                        if (prev_ok && fire) cap_phase = PH_RUN;
                        prev_val = smp[ch];
                        prev_ok  = 1'b1;
                    end
                end
                // store the sample set
                if (cap_phase == PH_RUN) begin
                    sample_store[fill_idx] = {smp[3], smp[2], smp[1], smp[0]};
                    entry_marked[fill_idx] = 1'b1;
                    if (fill_idx + 1 > ever_top) ever_top = fill_idx + 1;
                    fill_idx++;
                    if (fill_idx >= DEPTH) begin
                        cap_phase = PH_HOLD;
                        hold_left = cfg_holdoff;
                        st.done   = 1'b1;
                    end
                end
                // holdoff countdown, then rearm or stop
                if (cap_phase == PH_HOLD) begin
                    if (hold_left > 0) begin
                        hold_left--;
                    end else begin
                        fill_idx  = 0;
                        cap_phase = (cfg_mode == MODE_SINGLE) ? PH_STOP : PH_ARM;
                    end
                end
            end
        endcase
        st.phase = cap_phase;
        st.fill  = fill_idx[8:0];
    endtask

    // register write: setup cycle then access cycle
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRIG_MODE:    cfg_mode    = val[1:0];
            REG_TRIG_CHANNEL: cfg_chan    = val[2:0];
            REG_TRIG_LEVEL:   cfg_level   = val[15:0];
            REG_TRIG_RISING:  cfg_rising  = val[0];
            REG_HOLDOFF:      cfg_holdoff = val[15:0];
            default: ;
        endcase
    endtask

    // drive one input transfer, then record what it should produce
    task automatic send_item(input t_item it, input bit typed, input t_capture_status typed_st);
        int              gap;
        t_capture_status st;
        gap = idle_len(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {6'd0, it};
        do @(posedge clk); while (!s_ready);
        advance_capture(it, st);
        status_q.push_back(typed ? typed_st : st);
    endtask

    // hold the input quiet until every pending result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_result(input logic [79:0] d);
        t_capture_status want;
        if (status_q.size() == 0) begin
            report_mismatch("unexpected result", d[63:0], '0);
            return;
        end
        want = status_q.pop_front();
        if (d[1:0] !== want.phase)
            report_mismatch("phase", 64'(d[1:0]), 64'(want.phase));
        if (d[10:2] !== want.fill)
            report_mismatch("fill_count", 64'(d[10:2]), 64'(want.fill));
        if (d[11] !== want.done)
            report_mismatch("capture_done", 64'(d[11]), 64'(want.done));
        if (d[27:12] !== want.rd[15:0])
            report_mismatch("read_a", 64'(d[27:12]), 64'(want.rd[15:0]));
        if (d[43:28] !== want.rd[31:16])
            report_mismatch("read_b", 64'(d[43:28]), 64'(want.rd[31:16]));
        if (d[59:44] !== want.rd[47:32])
            report_mismatch("read_c", 64'(d[59:44]), 64'(want.rd[47:32]));
        if (d[75:60] !== want.rd[63:48])
            report_mismatch("read_d", 64'(d[75:60]), 64'(want.rd[63:48]));
    endtask

    // result side: take transfers and stall at random
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_valid === 1'b1 && out_ready) check_result(m_data);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                stall_left = idle_len(recv_calm);
            end
        end
    end

    function automatic t_dir_row cfg_row(input logic [2:0] idx, input logic [31:0] val);
        t_dir_row row;
        row = '{cmd: CMD_SAMPLE, ph: PH_STOP, default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = val;
        return row;
    endfunction

    function automatic t_dir_row item_row(input t_cmd c, input logic [15:0] a, b, cc, d,
                                          input logic [7:0] ad, input int reps, input bit rnd,
                                          input bit typed, input t_phase ph,
                                          input logic [8:0] fill, input logic done);
        t_dir_row row;
        row = '{cmd: CMD_SAMPLE, ph: PH_STOP, default: '0};
        row.cmd   = c;
        row.a     = a;
        row.b     = b;
        row.c     = cc;
        row.d     = d;
        row.addr  = ad;
        row.reps  = reps;
        row.rnd   = rnd;
        row.typed = typed;
        row.ph    = ph;
        row.fill  = fill;
        row.done  = done;
        return row;
    endfunction

    // stimulus
    initial begin
        t_dir_row        dir_rows [$];
        t_item           it;
        t_capture_status typed_st;
        int              rand_items, phase_no, len, r, trig_idx;
        int              wave, wave_dir, wave_step, wave_amp, lvl_i;
        bit              need_arm;
        logic [1:0]      w_mode;
        logic [2:0]      w_chan;
        logic [15:0]     w_level;
        logic            w_rising;
        logic [15:0]     w_hold;

        foreach (sample_store[i]) sample_store[i] = '0;
        foreach (entry_marked[i]) entry_marked[i] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; defaults after reset are auto mode, channel a, level 0, rising
        // sample while stopped is ignored, stop from stopped stays put
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 8'hff,
                                    1, 0, 1, PH_STOP, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_STOP, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 1, PH_STOP, 9'd0, 1'b0));
        // zero holdoff: the filling step rearms at once
        dir_rows.push_back(cfg_row(REG_HOLDOFF, 32'd0));
        dir_rows.push_back(item_row(CMD_ARM, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 8'h00,
                                    1, 0, 1, PH_RUN, 9'd1, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 8'h00,
                                    1, 0, 1, PH_RUN, 9'd2, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    253, 1, 0, PH_STOP, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b1));
        // read back the extremes, then masking after a fresh arm
        dir_rows.push_back(item_row(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 0, PH_STOP, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_READ, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff,
                                    1, 0, 0, PH_STOP, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_ARM, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_READ, 16'h0, 16'h0, 16'h0, 16'h0, 8'h01,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        // normal mode on channel c: first compare, equal level and wrong direction do not fire
        dir_rows.push_back(cfg_row(REG_TRIG_MODE, {30'd0, MODE_NORMAL}));
        dir_rows.push_back(cfg_row(REG_TRIG_CHANNEL, {29'd0, CHAN_C}));
        dir_rows.push_back(cfg_row(REG_TRIG_LEVEL, 32'h0000_0100));
        dir_rows.push_back(cfg_row(REG_TRIG_RISING, 32'd1));
        dir_rows.push_back(cfg_row(REG_HOLDOFF, 32'd3));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0200, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0100, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0101, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h00ff, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0101, 16'h0, 8'h00,
                                    1, 0, 1, PH_RUN, 9'd1, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    254, 1, 0, PH_STOP, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 1, PH_HOLD, 9'd256, 1'b1));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    3, 1, 0, PH_STOP, 9'd0, 1'b0));
        // single shot, falling, out-of-range channel code; previous value survives the rearm
        dir_rows.push_back(cfg_row(REG_TRIG_MODE, {30'd0, MODE_SINGLE}));
        dir_rows.push_back(cfg_row(REG_TRIG_RISING, 32'd0));
        dir_rows.push_back(cfg_row(REG_TRIG_CHANNEL, 32'd7));
        dir_rows.push_back(cfg_row(REG_TRIG_LEVEL, 32'h0000_ffff));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h8000, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 0, PH_STOP, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    258, 1, 0, PH_STOP, 9'd0, 1'b0));
        // mode three never fires
        dir_rows.push_back(cfg_row(REG_TRIG_MODE, {30'd0, MODE_NONE}));
        dir_rows.push_back(item_row(CMD_ARM, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_SAMPLE, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    5, 1, 1, PH_ARM, 9'd0, 1'b0));
        dir_rows.push_back(item_row(CMD_STOP, 16'h0, 16'h0, 16'h0, 16'h0, 8'h00,
                                    1, 0, 1, PH_STOP, 9'd0, 1'b0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                wait_drained();
                apb_write(dir_rows[k].reg_idx, dir_rows[k].value);
            end else begin
                for (int n = 0; n < dir_rows[k].reps; n++) begin
                    it.command      = dir_rows[k].cmd;
                    it.sample_a     = dir_rows[k].rnd ? 16'($urandom) : dir_rows[k].a;
                    it.sample_b     = dir_rows[k].rnd ? 16'($urandom) : dir_rows[k].b;
                    it.sample_c     = dir_rows[k].rnd ? 16'($urandom) : dir_rows[k].c;
                    it.sample_d     = dir_rows[k].rnd ? 16'($urandom) : dir_rows[k].d;
                    it.read_address = dir_rows[k].addr;
                    typed_st.phase  = dir_rows[k].ph;
                    typed_st.fill   = dir_rows[k].fill;
                    typed_st.done   = dir_rows[k].done;
                    typed_st.rd     = '0;
                    send_item(it, dir_rows[k].typed, typed_st);
                end
            end
        end

        // random phases, each under its own register setting
        rand_items = 0;
        phase_no   = 0;
        need_arm   = 1'b0;
        while (rand_items < RAND_ITEMS) begin
            phase_no++;
            r = $urandom_range(0, 9);
            w_mode   = (r < 3) ? MODE_AUTO : (r < 6) ? MODE_NORMAL : (r < 9) ? MODE_SINGLE
                                                                        : MODE_NONE;
            w_chan   = 3'($urandom_range(0, 7));
            w_level  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 4000) - 2000);
            w_rising = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 19);
            w_hold   = (r < 14) ? 16'($urandom_range(0, 16)) :
                       (r < 18) ? 16'($urandom_range(17, 400)) : 16'($urandom_range(0, 1));
            // push the register extremes in early phases
            case (phase_no)
                1: begin w_mode = MODE_NORMAL; w_hold = 16'd0; end
                2: begin w_level = 16'h7fff; w_chan = 3'd0; w_rising = 1'b1; end
                3: begin w_hold = 16'hffff; w_mode = MODE_AUTO; end
                4: begin w_level = 16'h8000; w_chan = 3'd7; w_rising = 1'b0; end
                5: begin w_chan = CHAN_D; w_mode = MODE_SINGLE; end
                default: ;
            endcase
            wait_drained();
            apb_write(REG_TRIG_MODE, {30'd0, w_mode});
            apb_write(REG_TRIG_CHANNEL, {29'd0, w_chan});
            apb_write(REG_TRIG_LEVEL, {16'd0, w_level});
            apb_write(REG_TRIG_RISING, {31'd0, w_rising});
            apb_write(REG_HOLDOFF, {16'd0, w_hold});

            // trigger channel follows a bouncing walk around the level
            trig_idx  = chan_index(w_chan);
            lvl_i     = int'($signed(w_level));
            wave      = lvl_i;
            wave_dir  = 1;
            wave_step = $urandom_range(1, 600);
            wave_amp  = $urandom_range(100, 3000);
            len       = $urandom_range(250, 450);
            for (int n = 0; n < len && rand_items < RAND_ITEMS; n++) begin
                it.sample_a     = 16'($urandom);
                it.sample_b     = 16'($urandom);
                it.sample_c     = 16'($urandom);
                it.sample_d     = 16'($urandom);
                it.read_address = 8'($urandom);
                r = $urandom_range(0, 99);
                if ((n == 0 && $urandom_range(0, 4) != 0) || need_arm) begin
                    it.command = CMD_ARM;
                    need_arm   = 1'b0;
                end else if (r < 88) begin
                    it.command = CMD_SAMPLE;
                end else if (r < 95) begin
                    it.command = CMD_READ;
                end else if (r < 98) begin
                    it.command = CMD_ARM;
                end else begin
                    it.command = CMD_STOP;
                    need_arm   = 1'b1;
                end
                // only read entries that have been written since reset
                if (it.command == CMD_READ) begin
                    if (ever_top == 0) it.command = CMD_SAMPLE;
                    else it.read_address = 8'($urandom_range(0, ever_top - 1));
                end
                if (it.command == CMD_SAMPLE && $urandom_range(0, 99) >= 15) begin
                    if ($urandom_range(0, 19) == 0) wave = lvl_i;
                    else wave += wave_dir * $urandom_range(1, wave_step);
                    if (wave >= lvl_i + wave_amp || wave >= 32767) wave_dir = -1;
                    if (wave <= lvl_i - wave_amp || wave <= -32768) wave_dir = 1;
                    if (wave > 32767) wave = 32767;
                    if (wave < -32768) wave = -32768;
                    case (trig_idx)
                        1:       it.sample_b = 16'(wave);
                        2:       it.sample_c = 16'(wave);
                        3:       it.sample_d = 16'(wave);
                        default: it.sample_a = 16'(wave);
                    endcase
                end
                rand_items++;
                send_item(it, 1'b0, '0);
            end
        end

        // drain, then a short tail for anything stray
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && status_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ctrl.sv
hw/rtl/tcc_store.sv
hw/rtl/triggered_four_channel_capture.sv
test/tb_triggered_four_channel_capture.sv
